// ===== hdl/psrp_pkg.sv =====
// Shared types and constants for the pointing stick report processor.
// No dependencies.
package psrp_pkg;

   localparam logic [4:0] EV_SYNC = 5'd0;
   localparam logic [4:0] EV_KEY  = 5'd1;
   localparam logic [4:0] EV_REL  = 5'd2;
   localparam logic [4:0] EV_ABS  = 5'd3;

   localparam logic [9:0] CODE_REPORT   = 10'h000;
   localparam logic [9:0] CODE_X        = 10'h000;
   localparam logic [9:0] CODE_Y        = 10'h001;
   localparam logic [9:0] CODE_LEFT     = 10'h110;
   localparam logic [9:0] CODE_RIGHT    = 10'h111;
   localparam logic [9:0] CODE_MIDDLE   = 10'h112;
   localparam logic [9:0] CODE_PRESSURE = 10'h018;

   localparam logic [2:0] REG_RAW       = 3'd0;
   localparam logic [2:0] REG_SENS      = 3'd1;
   localparam logic [2:0] REG_SCROLL    = 3'd2;
   localparam logic [2:0] REG_TIMEOUT   = 3'd3;
   localparam logic [2:0] REG_PSEL      = 3'd4;
   localparam logic [2:0] REG_THRESHOLD = 3'd5;

   localparam logic       RESULT_BUTTON = 1'b0;
   localparam logic       RESULT_MOTION = 1'b1;

   localparam logic [2:0] BUTTON_NONE        = 3'd0;
   localparam logic [2:0] BUTTON_LEFT        = 3'd1;
   localparam logic [2:0] BUTTON_MIDDLE      = 3'd2;
   localparam logic [2:0] BUTTON_RIGHT       = 3'd3;
   localparam logic [2:0] BUTTON_WHEEL_UP    = 3'd4;
   localparam logic [2:0] BUTTON_WHEEL_DOWN  = 3'd5;
   localparam logic [2:0] BUTTON_WHEEL_LEFT  = 3'd6;
   localparam logic [2:0] BUTTON_WHEEL_RIGHT = 3'd7;

   localparam logic signed [31:0] PRESSURE_MAX = 32'sd250;
   localparam logic [8:0]         DIV_BASE     = 9'd256;

   // classified word handed from the front part to the back part
   typedef struct packed {
      logic [4:0]         kind;    // EV_* (only sync/key/rel/abs pass)
      logic [9:0]         code;
      logic signed [31:0] value;
      logic [31:0]        now_ms;
   } event_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         button;
      logic               down;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic               last;
   } result_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)       return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

endpackage

// ===== hdl/pointing_stick_report_processor_unit.sv =====
// Top level of the pointing stick report processor.
// Depends on psrp_pkg, psrp_front, psrp_back.
//
// Event words (sync, key, relative, absolute) enter on the req_ channel and
// land in a two-entry queue; ignored words are accepted and dropped there, and
// req_stall rises only while the queue is full. The back part takes one queued
// word at a time. A sync report that ends in scaled motion goes through the
// sequencing steps plus two passes of the shift-subtract divider, one per axis.
// Scroll hold adds wheel clicks; raw mode skips the divider; runs that stop
// early are shorter. Any cycle in which a result word is due waits while the
// result register is stalled. Result words leave on the rsp_ channel in order,
// the last one of a run flagged by rsp_last_of_run. Registers are written on
// the csr_ port and must only change while no word is in flight.
module pointing_stick_report_processor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_event_type,
   input  logic [9:0]         req_event_code,
   input  logic signed [31:0] req_event_value,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [2:0]         rsp_button_number,
   output logic               rsp_button_down,
   output logic signed [31:0] rsp_move_x,
   output logic signed [31:0] rsp_move_y,
   output logic               rsp_last_of_run
);
   import psrp_pkg::*;

   // register file
   logic raw_ff, scroll_ff, psel_ff;
   logic [7:0] sens_ff;
   logic [15:0] tmo_ff;
   logic [6:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= 1'b0; sens_ff <= 8'd100; scroll_ff <= 1'b1;
         tmo_ff <= 16'd100; psel_ff <= 1'b0; thr_ff <= 7'd8;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RAW:       raw_ff    <= csr_data[0];
            REG_SENS:      sens_ff   <= csr_data[7:0];
            REG_SCROLL:    scroll_ff <= csr_data[0];
            REG_TIMEOUT:   tmo_ff    <= csr_data;
            REG_PSEL:      psel_ff   <= csr_data[0];
            REG_THRESHOLD: thr_ff    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // queue between front and back
   logic q_valid, q_take;
   event_type q_word;
   result_type r;

   psrp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_event_type, .req_event_code,
      .req_event_value, .req_now_ms, .q_valid, .q_take, .q_word
   );

   psrp_back u_back (
      .clock, .reset, .cfg_raw(raw_ff), .cfg_sens(sens_ff), .cfg_scroll(scroll_ff),
      .cfg_timeout(tmo_ff), .cfg_psel(psel_ff), .cfg_threshold(thr_ff),
      .q_valid, .q_take, .q_word, .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_word(r)
   );

   // result word fields
   assign rsp_result_kind   = r.kind;
   assign rsp_button_number = r.button;
   assign rsp_button_down   = r.down;
   assign rsp_move_x        = r.move_x;
   assign rsp_move_y        = r.move_y;
   assign rsp_last_of_run   = r.last;
endmodule

// ===== hdl/psrp_front.sv =====
// Front part: accepts input words, drops ignored events, queues the rest.
// Depends on psrp_pkg.
module psrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_event_type,
   input  logic [9:0]           req_event_code,
   input  logic signed [31:0]   req_event_value,
   input  logic [31:0]          req_now_ms,
   output logic                 q_valid,
   input  logic                 q_take,
   output psrp_pkg::event_type  q_word
);
   import psrp_pkg::*;

   // two-entry queue
   event_type  mem_ff [2];
   event_type  mem_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       keep, push;

   always_comb begin
      keep = 1'b0;
      case (req_event_type)
         EV_SYNC: keep = (req_event_code == CODE_REPORT);
         EV_KEY:  keep = (req_event_code == CODE_LEFT) || (req_event_code == CODE_RIGHT) ||
                         (req_event_code == CODE_MIDDLE);
         EV_REL:  keep = (req_event_code == CODE_X) || (req_event_code == CODE_Y);
         EV_ABS:  keep = (req_event_code == CODE_X) || (req_event_code == CODE_Y) ||
                         (req_event_code == CODE_PRESSURE);
         default: keep = 1'b0;
      endcase
      mem_in = '{kind: req_event_type, code: req_event_code,
                 value: req_event_value, now_ms: req_now_ms};
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != 2'd0);
   assign q_word    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= mem_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_take) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_take};
      end
   end
endmodule

// ===== hdl/psrp_div.sv =====
// Restoring divider: 32-bit signed dividend by 9-bit positive divisor,
// truncating toward zero. One quotient bit per cycle. Depends on psrp_pkg.
module psrp_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  dividend,
   input  logic [8:0]          divisor,
   output logic                done,
   output logic signed [31:0]  quotient
);
   import psrp_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] mag_ff;
   logic [8:0]  rem_ff, dvs_ff;
   logic        neg_ff;
   logic [9:0]  trial;
   logic [32:0] qmag;

   assign trial = {rem_ff, mag_ff[31]} - {1'b0, dvs_ff};
   assign qmag  = {1'b0, mag_ff};
   // a magnitude of 2^31 only comes from a negative dividend, so nothing clips
   assign quotient = neg_ff ? sat32(-$signed({31'd0, qmag})) : sat32($signed({31'd0, qmag}));
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         mag_ff <= dividend[31] ? (~dividend + 32'd1) : dividend;
         neg_ff <= dividend[31];
         rem_ff <= 9'd0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[9]) begin
            rem_ff <= trial[8:0];
            mag_ff <= {mag_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[7:0], mag_ff[31]};
            mag_ff <= {mag_ff[30:0], 1'b0};
         end
      end
   end
endmodule

// ===== hdl/psrp_back.sv =====
// Back part: keeps stick state, runs a report sequencer, emits result words.
// Depends on psrp_pkg and psrp_div.
module psrp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cfg_raw,
   input  logic [7:0]           cfg_sens,
   input  logic                 cfg_scroll,
   input  logic [15:0]          cfg_timeout,
   input  logic                 cfg_psel,
   input  logic [6:0]           cfg_threshold,
   input  logic                 q_valid,
   output logic                 q_take,
   input  psrp_pkg::event_type  q_word,
   output logic                 out_valid,
   input  logic                 out_stall,
   output psrp_pkg::result_type out_word
);
   import psrp_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RIGHT  = 4'd1;
   localparam logic [3:0] ST_PSEL   = 4'd2;
   localparam logic [3:0] ST_MID    = 4'd3;
   localparam logic [3:0] ST_MUP    = 4'd4;
   localparam logic [3:0] ST_PRESS  = 4'd5;
   localparam logic [3:0] ST_MULX   = 4'd6;
   localparam logic [3:0] ST_MULY   = 4'd7;
   localparam logic [3:0] ST_DIVX   = 4'd8;
   localparam logic [3:0] ST_DIVY   = 4'd9;
   localparam logic [3:0] ST_MOTION = 4'd10;
   localparam logic [3:0] ST_SCRY   = 4'd11;
   localparam logic [3:0] ST_SCRYU  = 4'd12;
   localparam logic [3:0] ST_SCRX   = 4'd13;
   localparam logic [3:0] ST_SCRXU  = 4'd14;
   localparam logic [3:0] ST_FINISH = 4'd15;

   logic [3:0]         state_ff, state_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, pres_ff, pres_in;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in;
   logic               left_ff, left_in, right_ff, right_in, mid_ff, mid_in;
   logic               latch_ff, latch_in, psel_ff, psel_in;
   logic [31:0]        dead_ff, dead_in, now_ff, now_in;

   // result register, plus one parked word that waits until we know if it is last
   logic               ov_ff, ov_in;
   result_type         ow_ff, ow_in, park_ff, park_in;
   logic               emit;
   result_type         emit_word;
   logic               slot_free;

   logic               div_start, div_done;
   logic signed [31:0] div_a, div_q;
   logic [8:0]         divisor;
   logic signed [31:0] mul_a, prod_sat;
   logic signed [40:0] prod;
   logic signed [31:0] dzx, dzy;
   logic               pres_ok;
   logic [31:0]        diff;
   logic [2:0]         wheel_y, wheel_x;

   function automatic result_type btn(input logic [2:0] b, input logic d, input logic l);
      return '{kind: RESULT_BUTTON, button: b, down: d, move_x: 32'sd0, move_y: 32'sd0,
               last: l};
   endfunction

   assign out_valid = ov_ff;
   assign out_word  = ow_ff;
   assign slot_free = !ov_ff || !out_stall;
   assign q_take    = (state_ff == ST_IDLE) && q_valid;

   assign divisor  = DIV_BASE - {1'b0, cfg_sens};
   assign dzx      = (!cfg_raw && dx_ff >= -32'sd2 && dx_ff <= 32'sd2) ? 32'sd0 : dx_ff;
   assign dzy      = (!cfg_raw && dy_ff >= -32'sd2 && dy_ff <= 32'sd2) ? 32'sd0 : dy_ff;
   assign pres_ok  = (pres_ff > 32'sd0) && (pres_ff <= PRESSURE_MAX);
   assign diff     = dead_ff - now_ff;
   // pressure is 1..250 once scaling starts, so 8 bits of it suffice
   assign mul_a    = (state_ff == ST_MULX) ? dx_ff : dy_ff;
   assign prod     = mul_a * $signed({1'b0, pres_ff[7:0]});
   assign prod_sat = sat32(64'(prod));
   assign div_a    = (state_ff == ST_MULY) ? sx_ff : sy_ff;
   assign wheel_y  = sy_ff[31] ? BUTTON_WHEEL_UP : BUTTON_WHEEL_DOWN;
   assign wheel_x  = sx_ff[31] ? BUTTON_WHEEL_LEFT : BUTTON_WHEEL_RIGHT;

   psrp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(divisor), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      state_in  = state_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      pres_in   = pres_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      mid_in    = mid_ff;
      latch_in  = latch_ff;
      psel_in   = psel_ff;
      dead_in   = dead_ff;
      now_in    = now_ff;
      ov_in     = ov_ff && out_stall;
      ow_in     = ow_ff;
      park_in   = park_ff;
      emit      = 1'b0;
      emit_word = btn(BUTTON_LEFT, 1'b0, 1'b0);
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (q_valid) begin
            unique case (q_word.kind)
               EV_SYNC: begin
                  now_in   = q_word.now_ms;
                  park_in  = btn(BUTTON_LEFT, left_ff, 1'b0);
                  state_in = ST_RIGHT;
               end
               EV_KEY: begin
                  if (q_word.code == CODE_LEFT)   left_in  = (q_word.value != 0);
                  if (q_word.code == CODE_RIGHT)  right_in = (q_word.value != 0);
                  if (q_word.code == CODE_MIDDLE) mid_in   = (q_word.value != 0);
               end
               EV_REL: begin
                  if (q_word.code == CODE_X) dx_in = sat32(64'(dx_ff) + 64'(q_word.value));
                  else dy_in = sat32(64'(dy_ff) + 64'(q_word.value));
               end
               EV_ABS: begin
                  if (q_word.code == CODE_X) dx_in = q_word.value;
                  else if (q_word.code == CODE_Y) dy_in = q_word.value;
                  else pres_in = q_word.value;
               end
               default: ;
            endcase
         end
         ST_RIGHT: if (slot_free) begin
            emit      = 1'b1;
            emit_word = btn(BUTTON_RIGHT, right_ff, 1'b0);
            state_in  = ST_PSEL;
         end
         ST_PSEL: if (slot_free) begin
            if (!cfg_raw && cfg_psel) begin
               if (pres_ff > $signed({25'd0, cfg_threshold})) begin
                  psel_in   = 1'b1;
                  emit      = 1'b1;
                  emit_word = btn(BUTTON_LEFT, 1'b1, 1'b0);
               end else if (psel_ff) begin
                  psel_in   = 1'b0;
                  emit      = 1'b1;
                  emit_word = btn(BUTTON_LEFT, 1'b0, 1'b0);
               end
            end
            state_in = ST_MID;
         end
         ST_MID: if (slot_free) begin
            if (cfg_scroll) begin
               if (mid_ff) begin
                  if (!latch_ff) begin
                     latch_in = 1'b1;
                     dead_in  = {16'd0, cfg_timeout} + now_ff;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_PRESS;
                  end
               end else if (latch_ff) begin
                  latch_in = 1'b0;
                  // released before the deadline: middle click ends the run
                  if (diff != 32'd0 && !diff[31]) begin
                     emit      = 1'b1;
                     emit_word = btn(BUTTON_MIDDLE, 1'b1, 1'b0);
                     state_in  = ST_MUP;
                  end else begin
                     state_in = ST_PRESS;
                  end
               end else begin
                  state_in = ST_PRESS;
               end
            end else begin
               emit      = 1'b1;
               emit_word = btn(BUTTON_MIDDLE, mid_ff, 1'b0);
               state_in  = ST_PRESS;
            end
         end
         ST_MUP: if (slot_free) begin
            emit      = 1'b1;
            emit_word = btn(BUTTON_MIDDLE, 1'b0, 1'b0);
            state_in  = ST_FINISH;
         end
         ST_PRESS: begin
            if (pres_ok) begin
               dx_in    = dzx;
               dy_in    = dzy;
               state_in = ST_MULX;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MULX: begin
            sx_in    = prod_sat;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            sy_in = prod_sat;
            if (cfg_raw) begin
               state_in = ST_MOTION;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVX;
            end
         end
         ST_DIVX: if (div_done) begin
            sx_in     = div_q;
            div_start = 1'b1;
            state_in  = ST_DIVY;
         end
         ST_DIVY: if (div_done) begin
            sy_in    = div_q;
            state_in = ST_MOTION;
         end
         ST_MOTION: begin
            if (!cfg_scroll || !latch_ff) begin
               if (slot_free) begin
                  emit      = 1'b1;
                  emit_word = '{kind: RESULT_MOTION, button: BUTTON_NONE, down: 1'b0,
                                move_x: sx_ff, move_y: sy_ff, last: 1'b0};
                  state_in  = ST_FINISH;
               end
            end else begin
               state_in = ST_SCRY;
            end
         end
         ST_SCRY: begin
            if (sy_ff == 32'sd0) begin
               state_in = ST_SCRX;
            end else if (slot_free) begin
               emit      = 1'b1;
               emit_word = btn(wheel_y, 1'b1, 1'b0);
               state_in  = ST_SCRYU;
            end
         end
         ST_SCRYU: if (slot_free) begin
            emit      = 1'b1;
            emit_word = btn(wheel_y, 1'b0, 1'b0);
            state_in  = ST_SCRX;
         end
         ST_SCRX: begin
            if (sx_ff == 32'sd0) begin
               state_in = ST_FINISH;
            end else if (slot_free) begin
               emit      = 1'b1;
               emit_word = btn(wheel_x, 1'b1, 1'b0);
               state_in  = ST_SCRXU;
            end
         end
         ST_SCRXU: if (slot_free) begin
            emit      = 1'b1;
            emit_word = btn(wheel_x, 1'b0, 1'b0);
            state_in  = ST_FINISH;
         end
         ST_FINISH: if (slot_free) begin
            // parked word is the final one of the run
            ov_in      = 1'b1;
            ow_in      = park_ff;
            ow_in.last = 1'b1;
            if (cfg_raw) begin
               dx_in = 32'sd0;
               dy_in = 32'sd0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // a new word pushes the parked one into the result register
      if (emit) begin
         ov_in   = 1'b1;
         ow_in   = park_ff;
         park_in = emit_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dx_ff    <= 32'sd0;
         dy_ff    <= 32'sd0;
         pres_ff  <= 32'sd1;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
         mid_ff   <= 1'b0;
         latch_ff <= 1'b0;
         psel_ff  <= 1'b0;
         dead_ff  <= 32'd0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         pres_ff  <= pres_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         mid_ff   <= mid_in;
         latch_ff <= latch_in;
         psel_ff  <= psel_in;
         dead_ff  <= dead_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      now_ff  <= now_in;
      ow_ff   <= ow_in;
      park_ff <= park_in;
   end
endmodule

// ===== tb/pointing_stick_report_processor_checker.sv =====
// Scoreboard for the pointing stick report processor: watches the register
// port and both channels, predicts each report run and compares it.
// Depends on psrp_pkg.
module pointing_stick_report_processor_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [4:0]         req_event_type,
   input  logic [9:0]         req_event_code,
   input  logic signed [31:0] req_event_value,
   input  logic [31:0]        req_now_ms,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_result_kind,
   input  logic [2:0]         rsp_button_number,
   input  logic               rsp_button_down,
   input  logic signed [31:0] rsp_move_x,
   input  logic signed [31:0] rsp_move_y,
   input  logic               rsp_last_of_run,
   output int                 fail_count,
   output int                 pending
);
   import psrp_pkg::*;

   // register shadows
   logic        raw_mode, scroll_on, psel_on;
   logic [7:0]  sens;
   logic [15:0] click_window;
   logic [6:0]  threshold;

   // stick state
   logic signed [31:0] dx, dy, pressure;
   logic               left_dn, right_dn, middle_dn, middle_lock, selecting;
   logic [31:0]        deadline;

   result_type run_words[$];
   result_type expected_words[$];

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] scale_axis(input logic signed [31:0] d);
      longint prod;
      longint divisor;
      prod = longint'(d) * longint'(pressure);
      if (raw_mode) return clip32(prod);
      prod = clip32(prod);
      divisor = 256 - longint'(sens);
      return clip32(prod / divisor);
   endfunction

   task automatic push_word(input logic kind, input logic [2:0] btn, input logic down,
                            input logic signed [31:0] mx, input logic signed [31:0] my);
      result_type w;
      w.kind = kind; w.button = btn; w.down = down;
      w.move_x = mx; w.move_y = my; w.last = 1'b0;
      run_words.push_back(w);
   endtask

   task automatic push_click(input logic [2:0] btn);
      push_word(RESULT_BUTTON, btn, 1'b1, 0, 0);
      push_word(RESULT_BUTTON, btn, 1'b0, 0, 0);
   endtask

   task automatic build_report(input logic [31:0] now);
      logic [31:0]        remaining;
      logic signed [31:0] sx, sy;
      push_word(RESULT_BUTTON, BUTTON_LEFT, left_dn, 0, 0);
      push_word(RESULT_BUTTON, BUTTON_RIGHT, right_dn, 0, 0);
      if (!raw_mode && psel_on) begin
         if (pressure > $signed({25'd0, threshold})) begin
            selecting = 1'b1;
            push_word(RESULT_BUTTON, BUTTON_LEFT, 1'b1, 0, 0);
         end else if (selecting) begin
            selecting = 1'b0;
            push_word(RESULT_BUTTON, BUTTON_LEFT, 1'b0, 0, 0);
         end
      end
      if (scroll_on) begin
         if (middle_dn) begin
            if (!middle_lock) begin
               middle_lock = 1'b1;
               deadline = {16'd0, click_window} + now;
               return;
            end
         end else if (middle_lock) begin
            remaining = deadline - now;
            middle_lock = 1'b0;
            if (remaining != 0 && !remaining[31]) begin
               push_click(BUTTON_MIDDLE);
               return;
            end
         end
      end else begin
         push_word(RESULT_BUTTON, BUTTON_MIDDLE, middle_dn, 0, 0);
      end
      if (pressure <= 0 || pressure > PRESSURE_MAX) return;
      if (!raw_mode) begin
         if (dx >= -2 && dx <= 2) dx = 0;
         if (dy >= -2 && dy <= 2) dy = 0;
      end
      sx = scale_axis(dx);
      sy = scale_axis(dy);
      if (!scroll_on || !middle_lock) begin
         push_word(RESULT_MOTION, BUTTON_NONE, 1'b0, sx, sy);
         return;
      end
      if (sy != 0) push_click(sy < 0 ? BUTTON_WHEEL_UP : BUTTON_WHEEL_DOWN);
      if (sx != 0) push_click(sx < 0 ? BUTTON_WHEEL_LEFT : BUTTON_WHEEL_RIGHT);
   endtask

   task automatic predict_event(input logic [4:0] et, input logic [9:0] ec,
                                input logic signed [31:0] ev, input logic [31:0] now);
      result_type w;
      run_words.delete();
      case (et)
         EV_SYNC: if (ec == CODE_REPORT) begin
            build_report(now);
            if (raw_mode) begin
               dx = 0;
               dy = 0;
            end
            if (run_words.size() > 0) begin
               w = run_words.pop_back();
               w.last = 1'b1;
               run_words.push_back(w);
            end
         end
         EV_KEY: begin
            if (ec == CODE_LEFT) left_dn = ev != 0;
            else if (ec == CODE_RIGHT) right_dn = ev != 0;
            else if (ec == CODE_MIDDLE) middle_dn = ev != 0;
         end
         EV_REL: begin
            if (ec == CODE_X) dx = clip32(longint'(dx) + longint'(ev));
            else if (ec == CODE_Y) dy = clip32(longint'(dy) + longint'(ev));
         end
         EV_ABS: begin
            if (ec == CODE_X) dx = ev;
            else if (ec == CODE_Y) dy = ev;
            else if (ec == CODE_PRESSURE) pressure = ev;
         end
         default: ;
      endcase
      foreach (run_words[i]) expected_words.push_back(run_words[i]);
   endtask

   task automatic compare_word();
      result_type w;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word kind=%0d btn=%0d down=%0d x=%0d y=%0d last=%0d",
                  $time, rsp_result_kind, rsp_button_number, rsp_button_down,
                  rsp_move_x, rsp_move_y, rsp_last_of_run);
         fail_count++;
         return;
      end
      w = expected_words.pop_front();
      if (w.kind !== rsp_result_kind || w.button !== rsp_button_number ||
          w.down !== rsp_button_down || w.move_x !== rsp_move_x ||
          w.move_y !== rsp_move_y || w.last !== rsp_last_of_run) begin
         $display("%0t: mismatch expected kind=%0d btn=%0d down=%0d x=%0d y=%0d last=%0d",
                  $time, w.kind, w.button, w.down, w.move_x, w.move_y, w.last);
         $display("%0t:          actual   kind=%0d btn=%0d down=%0d x=%0d y=%0d last=%0d",
                  $time, rsp_result_kind, rsp_button_number, rsp_button_down,
                  rsp_move_x, rsp_move_y, rsp_last_of_run);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         raw_mode = 1'b0; sens = 8'd100; scroll_on = 1'b1;
         click_window = 16'd100; psel_on = 1'b0; threshold = 7'd8;
         dx = 0; dy = 0; pressure = 1;
         left_dn = 0; right_dn = 0; middle_dn = 0; middle_lock = 0;
         deadline = 0; selecting = 0;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_RAW:       raw_mode = csr_data[0];
               REG_SENS:      sens = csr_data[7:0];
               REG_SCROLL:    scroll_on = csr_data[0];
               REG_TIMEOUT:   click_window = csr_data;
               REG_PSEL:      psel_on = csr_data[0];
               REG_THRESHOLD: threshold = csr_data[6:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) compare_word();
         if (req_valid && !req_stall)
            predict_event(req_event_type, req_event_code, req_event_value, req_now_ms);
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/pointing_stick_report_processor_unit_tb.sv =====
// Testbench top for the pointing stick report processor: drives event words
// and register writes, stalls the result side, and reports the verdict.
// Depends on psrp_pkg, the block and pointing_stick_report_processor_checker.
module pointing_stick_report_processor_unit_tb;
   import psrp_pkg::*;

   localparam logic [9:0] CODE_TOUCH = 10'h14a;
   localparam int SETTLE_CYCLES = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [4:0]         req_event_type = '0;
   logic [9:0]         req_event_code = '0;
   logic signed [31:0] req_event_value = '0;
   logic [31:0]        req_now_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_kind;
   logic [2:0]         rsp_button_number;
   logic               rsp_button_down;
   logic signed [31:0] rsp_move_x;
   logic signed [31:0] rsp_move_y;
   logic               rsp_last_of_run;
   int                 fail_count;
   int                 pending;

   // idling knobs, percent per cycle
   int          gap_pct = 0;
   int          stall_pct = 0;
   bit          hold_req = 0;   // asks the receiver for one long hold-off
   int          hold_left = 0;
   logic [31:0] clock_ms = 32'hffff_ff00;   // wraps early in the run

   always #5 clock = ~clock;

   pointing_stick_report_processor_unit uut (.*);

   pointing_stick_report_processor_checker chk (.*);

   // receiver: random stalls, or a long counted hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offer one word; returns after the edge that accepts it
   task automatic send_word(input logic [4:0] et, input logic [9:0] ec,
                            input logic signed [31:0] ev, input logic [31:0] now);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_event_type <= et;
      req_event_code <= ec;
      req_event_value <= ev;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_config(input logic raw, input logic [7:0] sens, input logic scroll,
                             input logic [15:0] tmo, input logic psel,
                             input logic [6:0] thr);
      drain();
      write_reg(REG_RAW, {15'd0, raw});
      write_reg(REG_SENS, {8'd0, sens});
      write_reg(REG_SCROLL, {15'd0, scroll});
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_PSEL, {15'd0, psel});
      write_reg(REG_THRESHOLD, {9'd0, thr});
   endtask

   // random word with a mostly small value, sometimes full width
   function automatic logic signed [31:0] rand_delta();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return 32'sh7fffffff - $urandom_range(3);
         2:       return 32'sh80000000 + $urandom_range(3);
         default: return $signed($urandom_range(600)) - 300;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_pressure();
      case ($urandom_range(11))
         0:       return 0;
         1:       return -$signed($urandom_range(1000));
         2:       return 251 + $urandom_range(10);
         3:       return $urandom();
         4:       return 250;
         default: return 1 + $urandom_range(249);
      endcase
   endfunction

   // one well-formed report frame: up to four events then a sync
   task automatic send_frame();
      int n;
      clock_ms += $urandom_range(3) == 0 ? $urandom() : $urandom_range(80);
      n = $urandom_range(4);
      repeat (n) begin
         case ($urandom_range(6))
            0: send_word(EV_KEY, CODE_LEFT, $urandom_range(1) ? $urandom() : 0, clock_ms);
            1: send_word(EV_KEY, CODE_RIGHT, $urandom_range(1), clock_ms);
            2: send_word(EV_KEY, CODE_MIDDLE, $urandom_range(1), clock_ms);
            3: send_word(EV_REL, CODE_X, rand_delta(), clock_ms);
            4: send_word(EV_REL, CODE_Y, rand_delta(), clock_ms);
            5: send_word(EV_ABS, $urandom_range(1) ? CODE_X : CODE_Y, rand_delta(), clock_ms);
            default: send_word(EV_ABS, CODE_PRESSURE, rand_pressure(), clock_ms);
         endcase
      end
      send_word(EV_SYNC, CODE_REPORT, $urandom(), clock_ms);
   endtask

   // ignored or stray words
   task automatic send_noise();
      case ($urandom_range(4))
         0: send_word(5'(4 + $urandom_range(27)), 10'($urandom()), $urandom(), $urandom());
         1: send_word(EV_SYNC, 10'(1 + $urandom_range(1022)), $urandom(), $urandom());
         2: send_word(EV_KEY, CODE_TOUCH, $urandom(), clock_ms);
         3: send_word(EV_KEY, 10'($urandom()), $urandom(), clock_ms);
         default: send_word(EV_SYNC, CODE_REPORT, 0, $urandom());
      endcase
   endtask

   task automatic random_phase(input int words);
      repeat (words) begin
         if ($urandom_range(9) < 8) send_frame();
         else send_noise();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset settings: scroll on, window 100 ms
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1000);           // idle report, pressure 1
      send_word(EV_REL, CODE_X, 32'sh7fffffff, 32'd1000);
      send_word(EV_REL, CODE_X, 32'sh7fffffff, 32'd1000);     // accumulation clips
      send_word(EV_REL, CODE_Y, 2, 32'd1000);                 // inside deadzone
      send_word(EV_ABS, CODE_PRESSURE, 250, 32'd1000);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1001);
      send_word(EV_ABS, CODE_X, 32'sh80000000, 32'd1001);
      send_word(EV_ABS, CODE_PRESSURE, 251, 32'd1001);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1002);           // pressure too high
      send_word(EV_ABS, CODE_PRESSURE, 0, 32'd1002);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1003);           // pressure zero
      send_word(EV_ABS, CODE_PRESSURE, 200, 32'd1003);
      send_word(EV_KEY, CODE_MIDDLE, 1, 32'd1004);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1004);           // middle latches
      send_word(EV_KEY, CODE_MIDDLE, 0, 32'd1050);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd1050);           // quick click
      send_word(EV_KEY, CODE_MIDDLE, 1, 32'd2000);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd2000);
      send_word(EV_REL, CODE_Y, -500, 32'd2001);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd2001);           // scroll hold
      send_word(EV_KEY, CODE_MIDDLE, 0, 32'd2100);
      send_word(EV_SYNC, CODE_REPORT, 0, 32'd2100);           // deadline reached, no click
      send_word(EV_KEY, CODE_TOUCH, 1, 32'd2100);
      send_word(EV_SYNC, 10'h3ff, -1, 32'hffffffff);
      send_word(5'h1f, 10'h3ff, 32'sh7fffffff, 32'hffffffff);

      // no idling, extreme settings: raw, full sensitivity, no scroll
      set_config(1'b1, 8'd255, 1'b0, 16'd0, 1'b1, 7'd127);
      random_phase(10);

      // sender mostly idle; opposite extremes, sensitivity zero
      set_config(1'b0, 8'd0, 1'b1, 16'hffff, 1'b1, 7'd1);
      gap_pct = 86;
      random_phase(10);

      // receiver mostly stalled, with one long hold-off while words keep coming
      set_config(1'b0, 8'd1, 1'b1, 16'd40, 1'b1, 7'd64);
      gap_pct = 0;
      stall_pct = 86;
      hold_req = 1;
      random_phase(10);

      // pause until everything is back, then both sides idle
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      gap_pct = 29;
      stall_pct = 29;
      set_config(1'($urandom_range(1)), 8'($urandom()), 1'($urandom_range(1)),
                 16'($urandom_range(300)), 1'($urandom_range(1)),
                 7'($urandom_range(1, 127)));
      random_phase(10);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
